/* src/dhlt_pkg.sv */
// Shared constants, CORDIC arctangent table and rounding helpers for the DH link transform.
package dhlt_pkg;

   // CORDIC datapath width: Q2.30 values with headroom for gain overshoot.
   localparam int CW = 34;

   localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1686629713;
   localparam logic signed [CW-1:0] ANG_PI      = 34'sd3373259426;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] Q14_POS     = 34'sd16384;
   localparam logic signed [CW-1:0] Q14_NEG     = -34'sd16384;
   localparam logic signed [CW-1:0] RND_Q30_Q14 = 34'sd32768;

   // Arctangent of 2^-idx in Q2.30 radians.
   function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [CW-1:0] val;
      unique case (idx)
         5'd0:  val = 34'sh3243F6A8;
         5'd1:  val = 34'sh1DAC6705;
         5'd2:  val = 34'sh0FADBAFC;
         5'd3:  val = 34'sh07F56EA6;
         5'd4:  val = 34'sh03FEAB76;
         5'd5:  val = 34'sh01FFD55B;
         5'd6:  val = 34'sh00FFFAAA;
         5'd7:  val = 34'sh007FFF55;
         5'd8:  val = 34'sh003FFFEA;
         5'd9:  val = 34'sh001FFFFD;
         5'd10: val = 34'sh000FFFFF;
         5'd11: val = 34'sh0007FFFF;
         5'd12: val = 34'sh0003FFFF;
         5'd13: val = 34'sh0001FFFF;
         5'd14: val = 34'sh0000FFFF;
         5'd15: val = 34'sh00007FFF;
         5'd16: val = 34'sh00003FFF;
         5'd17: val = 34'sh00001FFF;
         5'd18: val = 34'sh00000FFF;
         5'd19: val = 34'sh000007FF;
         5'd20: val = 34'sh000003FF;
         5'd21: val = 34'sh000001FF;
         5'd22: val = 34'sh000000FF;
         5'd23: val = 34'sh0000007F;
         5'd24: val = 34'sh0000003F;
         5'd25: val = 34'sh0000001F;
         5'd26: val = 34'sh0000000F;
         5'd27: val = 34'sh00000007;
         5'd28: val = 34'sh00000003;
         5'd29: val = 34'sh00000001;
         5'd30: val = 34'sh00000000;
         5'd31: val = 34'sh00000000;
      endcase
      return val;
   endfunction

   // Product of two Q1.14 values back to Q1.14, rounded half up.
   function automatic logic signed [15:0] mul14_round(input logic signed [31:0] prod);
      logic signed [31:0] sum;
      sum = (prod + 32'sd8192) >>> 14;
      return sum[15:0];
   endfunction

endpackage

/* src/dhlt_cordic.sv */
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q3.13 angle in Q1.14.
module dhlt_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] angle,
   output logic signed [15:0] sin_out,
   output logic signed [15:0] cos_out
);
   import dhlt_pkg::*;

   logic signed [CW-1:0] x_ff [0:STAGES];
   logic signed [CW-1:0] y_ff [0:STAGES];
   logic signed [CW-1:0] z_ff [0:STAGES];
   logic                 neg_ff [0:STAGES];

   logic signed [CW-1:0] z_raw;
   logic signed [CW-1:0] z_in;
   logic                 neg_in;

   // Widen to Q2.30 and fold by pi into the convergence range.
   always_comb begin
      z_raw = {angle[15], angle, 17'b0};
      priority if (z_raw > ANG_HALF_PI) begin
         z_in   = z_raw - ANG_PI;
         neg_in = 1'b1;
      end else if (z_raw < -ANG_HALF_PI) begin
         z_in   = z_raw + ANG_PI;
         neg_in = 1'b1;
      end else begin
         z_in   = z_raw;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign at = atan_entry(5'(i));

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   logic signed [CW-1:0] xr, yr, xc, yc;
   logic signed [15:0]   cos_in, sin_in;
   logic signed [15:0]   cos_ff, sin_ff;

   // Round Q2.30 to Q1.14, clamp to plus or minus one, then undo the fold.
   always_comb begin
      xr = (x_ff[STAGES] + RND_Q30_Q14) >>> 16;
      yr = (y_ff[STAGES] + RND_Q30_Q14) >>> 16;
      xc = (xr > Q14_POS) ? Q14_POS : ((xr < Q14_NEG) ? Q14_NEG : xr);
      yc = (yr > Q14_POS) ? Q14_POS : ((yr < Q14_NEG) ? Q14_NEG : yr);
      cos_in = neg_ff[STAGES] ? -xc[15:0] : xc[15:0];
      sin_in = neg_ff[STAGES] ? -yc[15:0] : yc[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

/* src/dh_link_transform_core.sv */
// Top level of the Denavit-Hartenberg link transform pipeline.
//
// Each input word carries the four DH parameters of one link (a, alpha, d, theta) and
// produces one output word with the top three rows of the homogeneous link transform,
// leaving out the constant zero at row two, column zero and the bottom row. Sine and
// cosine of both angles come from two pipelined CORDIC units of CORDIC_STAGES steps
// each; every angle code is accepted because a fold by pi brings it into range. The
// rotation entries are Q1.14, translations are Q16.16 with px and py saturated to the
// signed 32 bit range, and pz is d unchanged. The block takes one word per clock cycle
// while the output is not stalled, and the delay from acceptance to each result is
// set by the CORDIC pipeline plus one multiply stage and one output register. All
// stages advance together: while a result waits on rsp_tready the whole pipeline holds
// and req_tready is low, and no word is lost or repeated.
module dh_link_transform_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: link_length[31:0], twist_angle[47:32], link_offset[79:48],
   // joint_angle[95:80].
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: r00[15:0], r01[31:16], r02[47:32], px[79:48], r10[95:80],
   // r11[111:96], r12[127:112], py[159:128], r21[175:160], r22[191:176], pz[223:192].
   output logic [223:0] rsp_tdata
);
   import dhlt_pkg::*;

   localparam int LAT = CORDIC_STAGES + 2;

   logic en;
   logic rsp_valid_ff;

   // The pipeline moves whenever the output register is empty or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   logic signed [31:0] req_a, req_d;
   logic signed [15:0] req_alpha, req_theta;
   assign req_a     = req_tdata[31:0];
   assign req_alpha = req_tdata[47:32];
   assign req_d     = req_tdata[79:48];
   assign req_theta = req_tdata[95:80];

   // Sine and cosine of theta and alpha.
   logic signed [15:0] st, ct, sa, ca;

   dhlt_cordic #(.STAGES(CORDIC_STAGES)) u_theta (
      .clock   (clock),
      .en      (en),
      .angle   (req_theta),
      .sin_out (st),
      .cos_out (ct)
   );

   dhlt_cordic #(.STAGES(CORDIC_STAGES)) u_alpha (
      .clock   (clock),
      .en      (en),
      .angle   (req_alpha),
      .sin_out (sa),
      .cos_out (ca)
   );

   // The link length and offset ride alongside the CORDIC latency, with a valid bit
   // per stage.
   logic signed [31:0] a_dly_ff [0:LAT-1];
   logic signed [31:0] d_dly_ff [0:LAT-1];
   logic [LAT-1:0]     vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dly_ff[0] <= req_a;
         d_dly_ff[0] <= req_d;
         for (int k = 1; k < LAT; k++) begin
            a_dly_ff[k] <= a_dly_ff[k-1];
            d_dly_ff[k] <= d_dly_ff[k-1];
         end
      end
   end

   // Multiply stage: raw products, registered before rounding.
   logic               mul_vld_ff;
   logic signed [31:0] p_stca_ff, p_stsa_ff, p_ctca_ff, p_ctsa_ff;
   logic signed [47:0] p_act_ff, p_ast_ff;
   logic signed [15:0] m_st_ff, m_ct_ff, m_sa_ff, m_ca_ff;
   logic signed [31:0] m_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (en) begin
         mul_vld_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_stca_ff <= 32'(st) * 32'(ca);
         p_stsa_ff <= 32'(st) * 32'(sa);
         p_ctca_ff <= 32'(ct) * 32'(ca);
         p_ctsa_ff <= 32'(ct) * 32'(sa);
         p_act_ff  <= 48'(a_dly_ff[LAT-1]) * 48'(ct);
         p_ast_ff  <= 48'(a_dly_ff[LAT-1]) * 48'(st);
         m_st_ff   <= st;
         m_ct_ff   <= ct;
         m_sa_ff   <= sa;
         m_ca_ff   <= ca;
         m_d_ff    <= d_dly_ff[LAT-1];
      end
   end

   // Rounding, negation after rounding, and saturation of the translations.
   logic signed [47:0] px_sh, py_sh;
   logic signed [31:0] px_in, py_in;
   logic signed [15:0] r01_in, r02_in, r11_in, r12_in;

   always_comb begin
      r01_in = -mul14_round(p_stca_ff);
      r02_in =  mul14_round(p_stsa_ff);
      r11_in =  mul14_round(p_ctca_ff);
      r12_in = -mul14_round(p_ctsa_ff);
      px_sh  = (p_act_ff + 48'sd8192) >>> 14;
      py_sh  = (p_ast_ff + 48'sd8192) >>> 14;
      priority if (px_sh > 48'sd2147483647) begin
         px_in = 32'sh7FFFFFFF;
      end else if (px_sh < -48'sd2147483648) begin
         px_in = 32'sh80000000;
      end else begin
         px_in = px_sh[31:0];
      end
      priority if (py_sh > 48'sd2147483647) begin
         py_in = 32'sh7FFFFFFF;
      end else if (py_sh < -48'sd2147483648) begin
         py_in = 32'sh80000000;
      end else begin
         py_in = py_sh[31:0];
      end
   end

   logic [223:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {m_d_ff, m_ca_ff, m_sa_ff, py_in, r12_in, r11_in, m_st_ff,
                         px_in, r02_in, r01_in, m_ct_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/sv/dh_link_transform_check.sv */
// Watches both channels of the DH link transform, predicts each result and compares it.
`timescale 1ns / 1ps

module dh_link_transform_check #(
   parameter int STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [223:0] rsp_tdata,
   output int           mismatches,
   output int           pending
);

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint GAIN_Q30    = 64'sd652032874;

   localparam longint ATAN_Q30 [32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h3F, 64'h1F, 64'h0F, 64'h07, 64'h03, 64'h01, 64'h00, 64'h00
   };

   // Result fields from bit 0 up.
   localparam int FIELD_LSB [11] = '{0, 16, 32, 48, 80, 96, 112, 128, 160, 176, 192};
   localparam int FIELD_W   [11] = '{16, 16, 16, 32, 16, 16, 16, 32, 16, 16, 32};

   logic [223:0] frames_due [$];
   int           mismatch_total = 0;
   int           waiting = 0;

   assign mismatches = mismatch_total;
   assign pending    = waiting;

   function automatic string field_name(input int f);
      case (f)
         0:  return "r00";
         1:  return "r01";
         2:  return "r02";
         3:  return "px";
         4:  return "r10";
         5:  return "r11";
         6:  return "r12";
         7:  return "py";
         8:  return "r21";
         9:  return "r22";
         default: return "pz";
      endcase
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint q14_mul(input longint a, input longint b);
      return (a * b + 8192) >>> 14;
   endfunction

   // Sine and cosine of a Q3.13 angle in Q1.14, folded by pi into CORDIC range.
   function automatic void sin_cos_q14(input logic signed [15:0] ang,
                                       output longint sn, output longint cs);
      longint z, x, y, dx, dy;
      bit     flip;
      z    = longint'(ang) * 131072;
      x    = GAIN_Q30;
      y    = 0;
      flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z    = z - PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z    = z + PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_Q30[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_Q30[i];
         end
      end
      x  = clip((x + 32768) >>> 16, -16384, 16384);
      y  = clip((y + 32768) >>> 16, -16384, 16384);
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   // Top three rows of the homogeneous transform for one link word.
   function automatic logic [223:0] link_frame(input logic [95:0] w);
      longint       a, st, ct, sa, ca;
      logic [223:0] r;
      a = longint'($signed(w[31:0]));
      sin_cos_q14(w[95:80], st, ct);
      sin_cos_q14(w[47:32], sa, ca);
      r[15:0]    = 16'(ct);
      r[31:16]   = 16'(-q14_mul(st, ca));
      r[47:32]   = 16'(q14_mul(st, sa));
      r[79:48]   = 32'(clip(q14_mul(a, ct), -64'sd2147483648, 64'sd2147483647));
      r[95:80]   = 16'(st);
      r[111:96]  = 16'(q14_mul(ct, ca));
      r[127:112] = 16'(-q14_mul(ct, sa));
      r[159:128] = 32'(clip(q14_mul(a, st), -64'sd2147483648, 64'sd2147483647));
      r[175:160] = 16'(sa);
      r[191:176] = 16'(ca);
      r[223:192] = w[79:48];
      return r;
   endfunction

   always @(posedge clock) begin
      logic [223:0] due;
      logic [223:0] field_mask;
      logic [31:0]  want, got;
      bit           bad;
      if (!reset) begin
         // Retire the result first so a stray word can never match one accepted this edge.
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               $display("%0t: result word with none due, expected nothing, got %h",
                        $time, rsp_tdata);
               mismatch_total++;
            end else begin
               due = frames_due.pop_front();
               bad = 1'b0;
               for (int f = 0; f < 11; f++) begin
                  field_mask = (224'd1 << FIELD_W[f]) - 224'd1;
                  want = 32'((due >> FIELD_LSB[f]) & field_mask);
                  got  = 32'((rsp_tdata >> FIELD_LSB[f]) & field_mask);
                  if (want != got) begin
                     $display("%0t: %s expected %h, got %h", $time, field_name(f), want, got);
                     bad = 1'b1;
                  end
               end
               if (bad) mismatch_total++;
            end
         end
         if (req_tvalid && req_tready) begin
            frames_due.insert(frames_due.size(), link_frame(req_tdata));
         end
      end
      waiting <= frames_due.size();
   end

endmodule

/* tb/sv/dh_link_transform_core_test.sv */
// Stimulus and verdict for the DH link transform core, with the checker beside it.
`timescale 1ns / 1ps

module dh_link_transform_core_test;

   // Must match the block's CORDIC depth.
   localparam int STAGES      = 16;
   // Length of the deliberate output stall, long enough to fill the pipeline many times.
   localparam int HOLD_CYCLES = 300;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // Fields from bit 0: link_length[31:0], twist_angle[47:32], link_offset[79:48],
   // joint_angle[95:80].
   logic [95:0]  req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // Fields from bit 0: r00, r01, r02, px[79:48], r10, r11, r12, py[159:128], r21, r22,
   // pz[223:192].
   logic [223:0] rsp_tdata;

   int mismatches;
   int pending;

   // Idle odds in percent per cycle for each side; the stimulus changes them per phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Each increment asks the receiver for one long stall.
   int hold_asks = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dh_link_transform_core #(
      .CORDIC_STAGES(STAGES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   dh_link_transform_check #(
      .STAGES(STAGES)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .mismatches(mismatches),
      .pending   (pending)
   );

   // Receiver side. Normally ready is drawn at random each cycle; when a long stall is
   // asked for, ready stays low through a stall counted here, while the sender keeps
   // offering words so the pipeline fills and req_tready must drop.
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offers one word, possibly after a random gap, and returns at the edge that takes it.
   // Valid stays high on return so back-to-back words never drop it within a time step.
   task automatic send_link(input logic [31:0] len, input logic [15:0] twist,
                            input logic [31:0] offset, input logic [15:0] joint);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {joint, offset, twist, len};
      do @(posedge clock); while (!req_tready);
   endtask

   // Angles: mostly inside minus pi to pi, some raw codes anywhere in 16 bits, and some
   // hugging the fold points at plus and minus pi/2 and pi, or zero.
   function automatic logic [15:0] rand_angle();
      int base;
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1, 2: return 16'(int'($urandom_range(0, 51472)) - 25736);
         default: begin
            case ($urandom_range(0, 4))
               0: base = 12868;
               1: base = -12868;
               2: base = 25736;
               3: base = -25736;
               default: base = 0;
            endcase
            return 16'(base + int'($urandom_range(0, 4)) - 2);
         end
      endcase
   endfunction

   // Lengths: full-range codes, small values near zero, and the extremes that make
   // the translation products saturate.
   function automatic logic [31:0] rand_length();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return 32'(int'($urandom_range(0, 1048575)) - 524288);
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic send_random_links(input int count);
      repeat (count) send_link(rand_length(), rand_angle(), rand_length(), rand_angle());
   endtask

   initial begin
      // Angle codes for the directed words. The even slots hold the cases where a
      // cosine or sine of exactly minus one meets the most negative link length,
      // which is the only way px and py can saturate.
      logic [15:0] corner_angles [12];
      corner_angles = '{16'sd25736, 16'sd0, -16'sd25736, 16'sd32767, -16'sd12868,
                        -16'sd32768, 16'sd12868, 16'sd12867, 16'sd25735, -16'sd12869,
                        -16'sd25735, 16'sd6434};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles now and then, receiver idles often.
      send_idle_pct = 20;
      recv_idle_pct = 64;

      send_link(32'h0, 16'h0, 32'h0, 16'h0);
      for (int i = 0; i < 12; i++) begin
         send_link(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, corner_angles[11 - i],
                   i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, corner_angles[i]);
      end
      // Rounding of tiny lengths in both signs, all-ones codes everywhere, and alternating bits.
      send_link(32'h0000_0001, 16'sd6434, 32'h0000_0001, 16'sd6434);
      send_link(32'hFFFF_FFFF, -16'sd6434, 32'hFFFF_FFFF, -16'sd6434);
      send_link(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_link(32'h5555_5555, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA);
      send_random_links(470);

      // Phase two: the roles swap.
      send_idle_pct = 64;
      recv_idle_pct = 20;
      send_random_links(470);

      // Phase three: full rate both ways, with one long output stall in the middle.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_links(150);
      hold_asks++;
      send_random_links(310);
      req_tvalid <= 1'b0;

      // Drain, then give any stray word time to show up.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * STAGES + 8) @(posedge clock);

      if (mismatches == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
